// ===== sv/clcd_pkg.sv =====
// ============================================================================
// clcd_pkg
// Shared types and constants of the character LCD controller shadow.
// ============================================================================
package clcd_pkg;

    localparam int unsigned StoreDepth   = 144;
    localparam int unsigned DisplayDepth = 80;
    localparam int unsigned StoreAw      = $clog2(StoreDepth);

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_CMD  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [7:0] LINE1_LAST  = 8'd39;
    localparam logic [7:0] LINE2_FIRST = 8'd64;
    localparam logic [7:0] LINE2_LAST  = 8'd103;
    localparam logic [7:0] LINE2_END   = 8'd104;
    localparam logic [7:0] GLYPH_BASE  = 8'h80;
    localparam logic [7:0] LINE2_SKEW  = 8'd24;
    localparam logic [5:0] SHIFT_LAST  = 6'd39;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;

    localparam int unsigned FL_SCROLL = 0;
    localparam int unsigned FL_UP     = 1;
    localparam int unsigned FL_BLINK  = 2;
    localparam int unsigned FL_CURSOR = 3;
    localparam int unsigned FL_ON     = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic capture;
    } t_dp_cmd;

    typedef struct packed {
        logic is_read;
    } t_dp_sts;

endpackage

// ===== sv/clcd_ctrl.sv =====
// ============================================================================
// clcd_ctrl
// Sequencer: accept one transfer, execute it, wait for a store read, present.
// ============================================================================
module clcd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output clcd_pkg::t_dp_cmd o_cmd,
    input  clcd_pkg::t_dp_sts i_sts
);
    import clcd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = i_sts.is_read ? ST_RDWAIT : ST_OUT;
            end
            ST_RDWAIT: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        o_cmd         = '0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                o_cmd.load    = s_axis_tvalid;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            ST_RDWAIT: begin
                o_cmd.capture = 1'b1;
            end
            ST_OUT: begin
                m_axis_tvalid = 1'b1;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output open together");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("accepted second transfer while busy");
    a_read_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.exec && i_sts.is_read) |=> (o_cmd.capture && !m_axis_tvalid))
        else $error("read result presented before capture");
`endif

endmodule

// ===== sv/clcd_dp.sv =====
// ============================================================================
// clcd_dp
// Datapath: address counter, shift, mode flags, store memory and result.
// ============================================================================
module clcd_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  clcd_pkg::t_dp_cmd i_cmd,
    output clcd_pkg::t_dp_sts o_sts,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_data_byte,
    input  logic [7:0]        i_store_index,
    output logic [7:0]        o_panel_byte,
    output logic              o_panel_is_command,
    output logic              o_long_wait,
    output logic [7:0]        o_read_data,
    output logic [7:0]        o_cursor_address,
    output logic [5:0]        o_shift_amount,
    output logic [4:0]        o_flags
);
    import clcd_pkg::*;

    logic [1:0]             r_kind;
    logic [7:0]             r_byte;
    logic [7:0]             r_idx;
    logic [7:0]             r_addr,  n_addr;
    logic [5:0]             r_shift, n_shift;
    logic [4:0]             r_flags, n_flags;
    logic [7:0]             r_panel_byte, n_panel_byte;
    logic                   r_panel_cmd,  n_panel_cmd;
    logic                   r_long_wait,  n_long_wait;
    logic [7:0]             r_read_data;
    logic [7:0]             r_blank;
    logic [StoreDepth-1:0]  r_valid;
    logic [7:0]             mem [StoreDepth];
    logic [7:0]             r_rd_q;
    logic                   r_rd_ok;
    logic [7:0]             r_rd_fill;
    logic                   n_clear;
    logic                   wr_en;
    logic [StoreAw-1:0]     wr_addr;
    logic                   rd_in_range;
    logic [StoreAw-1:0]     rd_addr;

    function automatic logic [7:0] f_norm(input logic [7:0] a);
        logic [7:0] r;
        r = a;
        if (a > LINE1_LAST && a < LINE2_FIRST) begin
            r = LINE2_FIRST;
        end else if (a >= LINE2_END) begin
            r = 8'd0;
        end
        return r;
    endfunction

    function automatic logic [5:0] f_shift_up(input logic [5:0] s);
        return (s >= SHIFT_LAST) ? 6'd0 : s + 6'd1;
    endfunction

    function automatic logic [5:0] f_shift_dn(input logic [5:0] s);
        return (s == 6'd0 || s > SHIFT_LAST) ? SHIFT_LAST : s - 6'd1;
    endfunction

    always_comb begin
        logic up;
        logic [7:0] a;
        up           = r_flags[FL_UP];
        a            = r_addr;
        n_addr       = r_addr;
        n_shift      = r_shift;
        n_flags      = r_flags;
        n_panel_byte = 8'd0;
        n_panel_cmd  = 1'b0;
        n_long_wait  = 1'b0;
        n_clear      = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        case (r_kind)
            KIND_DATA: begin
                n_panel_byte = r_byte;
                if (a >= GLYPH_BASE) begin
                    wr_en   = 1'b1;
                    wr_addr = StoreAw'(DisplayDepth) + StoreAw'(a[5:0]);
                    a       = up ? a + 8'd1 : a - 8'd1;
                    n_addr  = GLYPH_BASE | {2'b00, a[5:0]};
                end else begin
                    if (a <= LINE1_LAST) begin
                        wr_en   = 1'b1;
                        wr_addr = StoreAw'(a);
                    end else if (a >= LINE2_FIRST && a <= LINE2_LAST) begin
                        wr_en   = 1'b1;
                        wr_addr = StoreAw'(a - LINE2_SKEW);
                    end
                    if (r_flags[FL_SCROLL]) begin
                        n_shift = up ? f_shift_up(r_shift) : f_shift_dn(r_shift);
                    end
                    if (a <= LINE1_LAST) begin
                        if (up) begin
                            n_addr = (a == LINE1_LAST) ? LINE2_FIRST : a + 8'd1;
                        end else begin
                            n_addr = (a == 8'd0) ? LINE2_LAST : a - 8'd1;
                        end
                    end else begin
                        a = up ? a + 8'd1 : a - 8'd1;
                        if (up && a == LINE2_END) begin
                            a = 8'd0;
                        end else if (!up && a == LINE2_FIRST - 8'd1) begin
                            a = LINE1_LAST;
                        end
                        n_addr = a;
                    end
                end
            end
            KIND_CMD: begin
                n_panel_byte = r_byte;
                n_panel_cmd  = 1'b1;
                if (r_byte[7]) begin
                    n_addr = f_norm({1'b0, r_byte[6:0]});
                end else if (r_byte[6]) begin
                    n_addr = GLYPH_BASE | {2'b00, r_byte[5:0]};
                end else if (r_byte[5]) begin
                    n_addr = r_addr;
                end else if (r_byte[4]) begin
                    if (r_byte[3]) begin
                        n_shift = r_byte[2] ? f_shift_dn(r_shift) : f_shift_up(r_shift);
                    end else begin
                        n_addr = f_norm(r_byte[2] ? r_addr + 8'd1 : r_addr - 8'd1);
                    end
                end else if (r_byte[3]) begin
                    n_flags[FL_ON]     = r_byte[2];
                    n_flags[FL_CURSOR] = r_byte[1];
                    n_flags[FL_BLINK]  = r_byte[0];
                end else if (r_byte[2]) begin
                    n_flags[FL_UP]     = r_byte[1];
                    n_flags[FL_SCROLL] = r_byte[0];
                end else if (r_byte[1]) begin
                    n_addr      = 8'd0;
                    n_shift     = 6'd0;
                    n_long_wait = 1'b1;
                end else if (r_byte[0]) begin
                    n_addr        = 8'd0;
                    n_shift       = 6'd0;
                    n_flags[FL_UP] = 1'b1;
                    n_long_wait   = 1'b1;
                    n_clear       = 1'b1;
                end
            end
            default: begin
                n_panel_byte = 8'd0;
            end
        endcase
    end

    assign rd_in_range = (r_idx < 8'(StoreDepth));
    assign rd_addr     = rd_in_range ? r_idx[StoreAw-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_byte <= i_data_byte;
            r_idx  <= i_store_index;
        end
        if (i_cmd.exec && wr_en) begin
            mem[wr_addr] <= r_byte;
        end
        if (i_cmd.exec) begin
            r_rd_q       <= mem[rd_addr];
            r_rd_ok      <= rd_in_range && r_valid[rd_addr];
            r_rd_fill    <= (r_idx < 8'(DisplayDepth)) ? r_blank : 8'd0;
            r_panel_byte <= n_panel_byte;
            r_panel_cmd  <= n_panel_cmd;
            r_long_wait  <= n_long_wait;
            r_read_data  <= 8'd0;
        end
        if (i_cmd.capture) begin
            r_read_data <= r_rd_ok ? r_rd_q : r_rd_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr  <= 8'd0;
            r_shift <= 6'd0;
            r_flags <= 5'd0;
            r_blank <= 8'd0;
            r_valid <= '0;
        end else if (i_cmd.exec) begin
            r_addr  <= n_addr;
            r_shift <= n_shift;
            r_flags <= n_flags;
            if (n_clear) begin
                r_blank                    <= CHAR_SPACE;
                r_valid[DisplayDepth-1:0]  <= '0;
            end
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    assign o_sts.is_read      = (r_kind == KIND_READ);
    assign o_panel_byte       = r_panel_byte;
    assign o_panel_is_command = r_panel_cmd;
    assign o_long_wait        = r_long_wait;
    assign o_read_data        = r_read_data;
    assign o_cursor_address   = r_addr;
    assign o_shift_amount     = r_shift;
    assign o_flags            = r_flags;

`ifndef NO_ASSERTIONS
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shift <= SHIFT_LAST)
        else $error("shift out of range");
    a_addr_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_addr > LINE1_LAST && r_addr < LINE2_FIRST)
          || (r_addr >= LINE2_END && r_addr < GLYPH_BASE)))
        else $error("address counter in a hole");
    a_wait_is_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> (!r_long_wait || r_panel_cmd))
        else $error("long wait without command");
`endif

endmodule

// ===== sv/char_lcd_controller_shadow_top.sv =====
// ============================================================================
// char_lcd_controller_shadow_top
// Shadow of a two-line character LCD controller with display and glyph stores.
// ============================================================================
// Input channel s_axis: tuser carries the item kind (data write, command,
// store read), tdata carries the byte and the read index. Output channel
// m_axis: one result per input transfer, with the forwarded byte, the
// command flag in tuser, the long-wait flag, the read-back entry and the
// address counter, shift and mode flags as they stand after the item.
// One item is in flight at a time. A data or command transfer passes through
// the execute state to the output state; a store read also passes through a
// read-wait state for the registered memory read port. A new item is accepted
// only after the previous result has been taken. A clear command writes no
// entries: per-entry valid bits and a blank value stand in for the fill.
// Reset clears the address counter, shift, mode flags and all valid bits, so
// both stores read as zero. While m_axis_tready is low the result holds and
// s_axis_tready stays low.
// ============================================================================
module char_lcd_controller_shadow_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // data_byte[7:0], store_index[15:8]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // panel_byte[7:0], long_wait[8],
                                        // read_data[16:9], cursor_address[24:17],
                                        // shift_amount[30:25], screen_on[31],
                                        // cursor_visible[32], cursor_blinks[33],
                                        // step_up[34], auto_scroll[35], zero[39:36]
    output logic        m_axis_tuser    // panel_is_command[0]
);
    import clcd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_sts    sts;
    logic [7:0] panel_byte;
    logic       long_wait;
    logic [7:0] read_data;
    logic [7:0] cursor_address;
    logic [5:0] shift_amount;
    logic [4:0] flags;

    clcd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_cmd         (cmd),
        .i_sts         (sts)
    );

    clcd_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_kind             (s_axis_tuser),
        .i_data_byte        (s_axis_tdata[7:0]),
        .i_store_index      (s_axis_tdata[15:8]),
        .o_panel_byte       (panel_byte),
        .o_panel_is_command (m_axis_tuser),
        .o_long_wait        (long_wait),
        .o_read_data        (read_data),
        .o_cursor_address   (cursor_address),
        .o_shift_amount     (shift_amount),
        .o_flags            (flags)
    );

    assign m_axis_tdata = {4'b0000,
                           flags[FL_SCROLL], flags[FL_UP], flags[FL_BLINK],
                           flags[FL_CURSOR], flags[FL_ON],
                           shift_amount, cursor_address, read_data,
                           long_wait, panel_byte};

`ifndef NO_ASSERTIONS
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_read_only_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[16:9] == 8'd0))
        else $error("read data on a command result");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("result repeated");
`endif

endmodule
